>>> rtl/itm_pkg.sv
`timescale 1ns / 1ps

package itm_pkg;

    localparam logic [7:0] MGMT_ENTITY = 8'h0f;
    localparam logic [6:0] DYN_BASE    = 7'd64;
    localparam logic [6:0] BCAST_TEI   = 7'd127;

    localparam logic [7:0] MT_REQUEST    = 8'd1;
    localparam logic [7:0] MT_ASSIGNED   = 8'd2;
    localparam logic [7:0] MT_DENIED     = 8'd3;
    localparam logic [7:0] MT_CHECK_REQ  = 8'd4;
    localparam logic [7:0] MT_CHECK_RESP = 8'd5;
    localparam logic [7:0] MT_REMOVE     = 8'd6;
    localparam logic [7:0] MT_VERIFY     = 8'd7;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [15:0] T201_RESET = 16'd1000;

    typedef struct packed {
        logic        opcode;
        logic        frame_ok;
        logic [7:0]  entity_id;
        logic [7:0]  msg_code;
        logic [15:0] reference_number;
        logic [6:0]  action_indicator;
    } item_t;

    typedef struct packed {
        logic [7:0]  send_type;
        logic [15:0] send_ref;
        logic [6:0]  send_tei;
    } result_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_init;
        logic scan_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic hit;
        logic last;
    } dp_status_t;

endpackage

>>> rtl/itm_ctrl.sv
`timescale 1ns / 1ps

module itm_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  itm_pkg::dp_status_t    status,
    output itm_pkg::ctrl_cmd_t     cmd,
    output logic                   busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd.load      = 1'b0;
        cmd.exec      = 1'b0;
        cmd.scan_init = 1'b0;
        cmd.scan_step = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.need_scan)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.hit || status.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> rtl/itm_dp.sv
`timescale 1ns / 1ps

module itm_dp
#(
    parameter int NUM_DYN_TEIS = 63,
    parameter int TIMER_WIDTH  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  itm_pkg::item_t         item,
    input  itm_pkg::ctrl_cmd_t     cmd,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata,
    output itm_pkg::dp_status_t    status,
    output logic                   done,
    output itm_pkg::result_t       result
);

    localparam int IDX_W = (NUM_DYN_TEIS > 1) ? $clog2(NUM_DYN_TEIS) : 1;
    localparam int CNT_W = $clog2(NUM_DYN_TEIS + 1);
    localparam logic [6:0] TOP_TEI = 7'(64 + NUM_DYN_TEIS - 1);
    localparam logic [7:0] END_TEI = 8'(64 + NUM_DYN_TEIS);
    localparam logic [31:0] TMAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_DYN_TEIS - 1);

    itm_pkg::item_t   item_reg;
    itm_pkg::result_t result_reg, result_next;
    logic             done_reg, done_next;

    logic [15:0]             t201_reg;
    logic [NUM_DYN_TEIS-1:0] in_use_reg, in_use_next;
    logic [6:0]              next_tei_reg, next_tei_next;
    logic                    active_reg, active_next;
    logic                    round_reg, round_next;
    logic [1:0]              fwc_reg, fwc_next;
    logic [1:0]              swc_reg, swc_next;
    logic [6:0]              checked_reg, checked_next;
    logic [TIMER_WIDTH-1:0]  window_reg, window_next;
    logic [6:0]              scan_p_reg, scan_p_next;
    logic [CNT_W-1:0]        scan_cnt_reg, scan_cnt_next;

    logic                   frame_valid;
    logic [6:0]             cand;
    logic [6:0]             cand_off;
    logic [IDX_W-1:0]       cand_idx;
    logic                   cand_free;
    logic [6:0]             chk_off;
    logic [IDX_W-1:0]       chk_idx;
    logic                   chk_in_table;
    logic [31:0]            t201_eff;
    logic [TIMER_WIDTH-1:0] win_load;
    logic [TIMER_WIDTH-1:0] win_dec;
    logic [6:0]             send_off;

    assign frame_valid = item_reg.frame_ok && (item_reg.entity_id == itm_pkg::MGMT_ENTITY);

    assign status.need_scan = (item_reg.opcode == itm_pkg::OP_FRAME) && frame_valid
                              && (item_reg.msg_code == itm_pkg::MT_REQUEST)
                              && (item_reg.action_indicator == itm_pkg::BCAST_TEI);

    // Next candidate after the pointer, wrapping at the top of the table.
    assign cand      = (scan_p_reg >= TOP_TEI) ? itm_pkg::DYN_BASE : scan_p_reg + 7'd1;
    assign cand_off  = cand - itm_pkg::DYN_BASE;
    assign cand_idx  = cand_off[IDX_W-1:0];
    assign cand_free = !in_use_reg[cand_idx];

    assign status.hit  = cand_free;
    assign status.last = (scan_cnt_reg == LAST_CNT);

    assign chk_off      = checked_reg - itm_pkg::DYN_BASE;
    assign chk_idx      = chk_off[IDX_W-1:0];
    assign chk_in_table = (checked_reg >= itm_pkg::DYN_BASE)
                          && ({1'b0, checked_reg} < END_TEI);

    // A zero window is taken as one tick; a long one saturates at the timer limit.
    assign t201_eff = (t201_reg == 16'd0) ? 32'd1 : {16'd0, t201_reg};
    assign win_load = (t201_eff > TMAX) ? TMAX[TIMER_WIDTH-1:0] : t201_eff[TIMER_WIDTH-1:0];
    assign win_dec  = (window_reg != '0) ? window_reg - TIMER_WIDTH'(1) : window_reg;

    always_comb
    begin
        in_use_next   = in_use_reg;
        next_tei_next = next_tei_reg;
        active_next   = active_reg;
        round_next    = round_reg;
        fwc_next      = fwc_reg;
        swc_next      = swc_reg;
        checked_next  = checked_reg;
        window_next   = window_reg;
        scan_p_next   = scan_p_reg;
        scan_cnt_next = scan_cnt_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        if (cmd.scan_init)
        begin
            if ((next_tei_reg < itm_pkg::DYN_BASE) || (next_tei_reg > TOP_TEI))
            begin
                scan_p_next = TOP_TEI;
            end
            else
            begin
                scan_p_next = next_tei_reg;
            end
            scan_cnt_next = '0;
        end

        if (cmd.scan_step)
        begin
            scan_p_next   = cand;
            scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            if (cand_free)
            begin
                in_use_next[cand_idx] = 1'b1;
                next_tei_next         = cand;
                done_next             = 1'b1;
                result_next.send_type = itm_pkg::MT_ASSIGNED;
                result_next.send_ref  = item_reg.reference_number;
                result_next.send_tei  = cand;
            end
            else if (status.last)
            begin
                next_tei_next         = cand;
                done_next             = 1'b1;
                result_next.send_type = itm_pkg::MT_DENIED;
                result_next.send_ref  = item_reg.reference_number;
                result_next.send_tei  = itm_pkg::BCAST_TEI;
            end
        end

        if (cmd.exec)
        begin
            if (item_reg.opcode == itm_pkg::OP_TICK)
            begin
                if (active_reg)
                begin
                    window_next = win_dec;
                    if (win_dec == '0)
                    begin
                        result_next.send_ref = 16'd0;
                        result_next.send_tei = checked_reg;
                        if (!round_reg)
                        begin
                            if (fwc_reg > 2'd1)
                            begin
                                active_next           = 1'b0;
                                done_next             = 1'b1;
                                result_next.send_type = itm_pkg::MT_REMOVE;
                            end
                            else
                            begin
                                round_next            = 1'b1;
                                window_next           = win_load;
                                done_next             = 1'b1;
                                result_next.send_type = itm_pkg::MT_CHECK_REQ;
                            end
                        end
                        else
                        begin
                            active_next = 1'b0;
                            if ((fwc_reg == 2'd0) && (swc_reg == 2'd0))
                            begin
                                // Nobody answered: the TEI is free again.
                                if (chk_in_table)
                                begin
                                    in_use_next[chk_idx] = 1'b0;
                                end
                            end
                            else if (!((fwc_reg == 2'd1) || (swc_reg == 2'd1)))
                            begin
                                done_next             = 1'b1;
                                result_next.send_type = itm_pkg::MT_REMOVE;
                            end
                        end
                    end
                end
            end
            else if (frame_valid)
            begin
                case (item_reg.msg_code)
                    itm_pkg::MT_REQUEST:
                    begin
                        // Broadcast Ai goes to the scan; static Ai is dropped; others are denied.
                        if (item_reg.action_indicator >= itm_pkg::DYN_BASE)
                        begin
                            done_next             = 1'b1;
                            result_next.send_type = itm_pkg::MT_DENIED;
                            result_next.send_ref  = item_reg.reference_number;
                            result_next.send_tei  = item_reg.action_indicator;
                        end
                    end
                    itm_pkg::MT_CHECK_RESP:
                    begin
                        if (active_reg)
                        begin
                            if (!round_reg)
                            begin
                                if (fwc_reg != 2'd3)
                                begin
                                    fwc_next = fwc_reg + 2'd1;
                                end
                            end
                            else if (swc_reg != 2'd3)
                            begin
                                swc_next = swc_reg + 2'd1;
                            end
                        end
                    end
                    itm_pkg::MT_VERIFY:
                    begin
                        if (item_reg.action_indicator != itm_pkg::BCAST_TEI)
                        begin
                            window_next           = win_load;
                            active_next           = 1'b1;
                            round_next            = 1'b0;
                            fwc_next              = 2'd0;
                            swc_next              = 2'd0;
                            checked_next          = item_reg.action_indicator;
                            done_next             = 1'b1;
                            result_next.send_type = itm_pkg::MT_CHECK_REQ;
                            result_next.send_ref  = 16'd0;
                            result_next.send_tei  = item_reg.action_indicator;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t201_reg     <= itm_pkg::T201_RESET;
            in_use_reg   <= '0;
            next_tei_reg <= itm_pkg::DYN_BASE;
            active_reg   <= 1'b0;
            round_reg    <= 1'b0;
            fwc_reg      <= 2'd0;
            swc_reg      <= 2'd0;
            checked_reg  <= 7'd0;
            window_reg   <= '0;
            scan_p_reg   <= itm_pkg::DYN_BASE;
            scan_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                t201_reg <= cfg_wdata;
            end
            in_use_reg   <= in_use_next;
            next_tei_reg <= next_tei_next;
            active_reg   <= active_next;
            round_reg    <= round_next;
            fwc_reg      <= fwc_next;
            swc_reg      <= swc_next;
            checked_reg  <= checked_next;
            window_reg   <= window_next;
            scan_p_reg   <= scan_p_next;
            scan_cnt_reg <= scan_cnt_next;
            done_reg     <= done_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    assign send_off = result_reg.send_tei - itm_pkg::DYN_BASE;

    a_result_code: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.send_type == itm_pkg::MT_ASSIGNED)
                  || (result_reg.send_type == itm_pkg::MT_DENIED)
                  || (result_reg.send_type == itm_pkg::MT_CHECK_REQ)
                  || (result_reg.send_type == itm_pkg::MT_REMOVE))
        else $error("result item carries an unknown message type");

    a_pointer_window: assert property (@(posedge clk) disable iff (!rst_n)
        (next_tei_reg >= itm_pkg::DYN_BASE) && (next_tei_reg <= TOP_TEI))
        else $error("allocation pointer left the dynamic TEI window");

    a_assigned_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.send_type == itm_pkg::MT_ASSIGNED))
            |-> in_use_reg[send_off[IDX_W-1:0]])
        else $error("assigned TEI is not marked in use");

    a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && !cand_free && !status.last) |=> !done_reg)
        else $error("scan reported a result before finding a free TEI or ending");

endmodule

>>> rtl/isdn_tei_manager_network_side_unit.sv
`timescale 1ns / 1ps

// Network-side TEI manager. An item is taken when start is high and busy is low.
// Ticks, check responses, verifies and requests that carry a specific Ai are
// executed without a scan: busy stays high for one clock and the result, if
// any, is on result for one clock with done high. A request with Ai 127 scans the
// TEI table one entry per clock from the rotating pointer, looking at 1 to
// NUM_DYN_TEIS entries until a free one is found or the table is exhausted.
// The receiver cannot stall the block: each result is shown for exactly one
// clock and must be captured then.
// Write t201_ticks through cfg_we/cfg_wdata only while the block is idle.
module isdn_tei_manager_network_side_unit
#(
    parameter int NUM_DYN_TEIS = 63,
    parameter int TIMER_WIDTH  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  itm_pkg::item_t     item,
    output logic               done,
    output itm_pkg::result_t   result,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);

    itm_pkg::ctrl_cmd_t  cmd;
    itm_pkg::dp_status_t status;

    itm_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    itm_dp
    #(
        .NUM_DYN_TEIS (NUM_DYN_TEIS),
        .TIMER_WIDTH  (TIMER_WIDTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int         NUM_TEIS      = 63;
    localparam logic [6:0] TOP_TEI       = 7'(itm_pkg::DYN_BASE + NUM_TEIS - 1);
    localparam int         SETTLE_CYCLES = 80;
    localparam int         CYCLE_LIMIT   = 1000000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    itm_pkg::item_t   item      = '0;
    logic             done;
    itm_pkg::result_t result;
    logic             cfg_we    = 1'b0;
    logic [15:0]      cfg_wdata = '0;

    isdn_tei_manager_network_side_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Shadow copy of the TEI manager state.
    bit          tei_taken [NUM_TEIS];
    logic [6:0]  alloc_ptr;
    bit          check_on;
    bit          check_second;
    logic [1:0]  resp_first;
    logic [1:0]  resp_second;
    logic [6:0]  probe_tei;
    logic [15:0] ticks_left;
    logic [15:0] t201_copy;

    itm_pkg::item_t   pending_items [$];
    itm_pkg::result_t predicted_msgs [$];
    itm_pkg::result_t want;

    int queued_count   = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int error_count    = 0;
    int settings_count = 0;
    int assigned_seen  = 0;
    int denied_seen    = 0;
    int check_seen     = 0;
    int remove_seen    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int gap_pick       = 0;
    int cycle_count    = 0;

    function automatic void restart_window();
        ticks_left = (t201_copy == 16'd0) ? 16'd1 : t201_copy;
    endfunction

    function automatic void queue_msg(logic [7:0] kind, logic [15:0] ref_no, logic [6:0] tei);
        itm_pkg::result_t r;
        r.send_type = kind;
        r.send_ref  = ref_no;
        r.send_tei  = tei;
        predicted_msgs.push_back(r);
    endfunction

    function automatic void allocate_tei(logic [15:0] ri);
        logic [6:0] p;
        bit         found;
        p     = alloc_ptr;
        found = 1'b0;
        if (p < itm_pkg::DYN_BASE || p > TOP_TEI)
            p = TOP_TEI;
        // Search starts just past the pointer and wraps round the table.
        for (int i = 0; i < NUM_TEIS && !found; i++)
        begin
            p = (p >= TOP_TEI) ? itm_pkg::DYN_BASE : p + 7'd1;
            if (!tei_taken[p - itm_pkg::DYN_BASE])
            begin
                tei_taken[p - itm_pkg::DYN_BASE] = 1'b1;
                found = 1'b1;
            end
        end
        alloc_ptr = p;
        if (found)
            queue_msg(itm_pkg::MT_ASSIGNED, ri, p);
        else
            queue_msg(itm_pkg::MT_DENIED, ri, itm_pkg::BCAST_TEI);
    endfunction

    function automatic void count_tick();
        if (!check_on)
            return;
        if (ticks_left != 16'd0)
            ticks_left--;
        if (ticks_left != 16'd0)
            return;
        if (!check_second)
        begin
            if (resp_first > 2'd1)
            begin
                check_on = 1'b0;
                queue_msg(itm_pkg::MT_REMOVE, 16'd0, probe_tei);
            end
            else
            begin
                check_second = 1'b1;
                restart_window();
                queue_msg(itm_pkg::MT_CHECK_REQ, 16'd0, probe_tei);
            end
        end
        else
        begin
            check_on = 1'b0;
            if (resp_first == 2'd0 && resp_second == 2'd0)
            begin
                if (probe_tei >= itm_pkg::DYN_BASE && probe_tei <= TOP_TEI)
                    tei_taken[probe_tei - itm_pkg::DYN_BASE] = 1'b0;
            end
            else if (!(resp_first == 2'd1 || resp_second == 2'd1))
                queue_msg(itm_pkg::MT_REMOVE, 16'd0, probe_tei);
        end
    endfunction

    function automatic void apply_mgmt_item(itm_pkg::item_t it);
        if (it.opcode == itm_pkg::OP_TICK)
            count_tick();
        else if (it.frame_ok && it.entity_id == itm_pkg::MGMT_ENTITY)
        begin
            case (it.msg_code)
                itm_pkg::MT_REQUEST:
                    if (it.action_indicator >= itm_pkg::DYN_BASE)
                    begin
                        if (it.action_indicator != itm_pkg::BCAST_TEI)
                            queue_msg(itm_pkg::MT_DENIED, it.reference_number,
                                      it.action_indicator);
                        else
                            allocate_tei(it.reference_number);
                    end
                itm_pkg::MT_CHECK_RESP:
                    if (check_on)
                    begin
                        if (!check_second)
                        begin
                            if (resp_first != 2'd3)
                                resp_first++;
                        end
                        else if (resp_second != 2'd3)
                            resp_second++;
                    end
                itm_pkg::MT_VERIFY:
                    if (it.action_indicator != itm_pkg::BCAST_TEI)
                    begin
                        restart_window();
                        check_on     = 1'b1;
                        check_second = 1'b0;
                        resp_first   = 2'd0;
                        resp_second  = 2'd0;
                        probe_tei    = it.action_indicator;
                        queue_msg(itm_pkg::MT_CHECK_REQ, 16'd0, it.action_indicator);
                    end
                default:
                    ;
            endcase
        end
    endfunction

    function automatic void queue_item(itm_pkg::item_t it);
        pending_items.push_back(it);
        queued_count++;
    endfunction

    function automatic itm_pkg::item_t frame_item(logic [7:0] kind, logic [15:0] ri,
                                                  logic [6:0] ai);
        itm_pkg::item_t it;
        it.opcode           = itm_pkg::OP_FRAME;
        it.frame_ok         = 1'b1;
        it.entity_id        = itm_pkg::MGMT_ENTITY;
        it.msg_code         = kind;
        it.reference_number = ri;
        it.action_indicator = ai;
        return it;
    endfunction

    // The frame fields of a tick carry random junk.
    function automatic itm_pkg::item_t tick_item();
        itm_pkg::item_t it;
        it = frame_item(8'($urandom), 16'($urandom), 7'($urandom));
        it.opcode    = itm_pkg::OP_TICK;
        it.frame_ok  = 1'($urandom_range(0, 1));
        it.entity_id = 8'($urandom);
        return it;
    endfunction

    function automatic itm_pkg::item_t noise_item();
        itm_pkg::item_t it;
        int             sel;
        sel = $urandom_range(0, 2);
        it  = frame_item((sel == 0) ? itm_pkg::MT_REQUEST :
                         (sel == 1) ? itm_pkg::MT_CHECK_RESP : itm_pkg::MT_VERIFY,
                         16'($urandom), 7'($urandom));
        case ($urandom_range(0, 3))
            0: it.frame_ok = 1'b0;
            1: it.entity_id = 8'($urandom);
            2: it.msg_code = 8'($urandom);
            default:
            begin
                it.frame_ok  = 1'($urandom_range(0, 1));
                it.entity_id = 8'($urandom);
                it.msg_code  = 8'($urandom);
            end
        endcase
        return it;
    endfunction

    // Queues one random scenario and returns how many of its items do real work.
    function automatic int add_scenario();
        int         pick;
        int         win;
        int         n;
        int         nt;
        int         r;
        int         count;
        logic [6:0] ai;
        count = 0;
        win   = (t201_copy == 16'd0) ? 1 : t201_copy;
        pick  = $urandom_range(0, 99);
        if (pick < 35)
        begin
            case ($urandom_range(0, 9))
                0: ai = 7'($urandom_range(64, 126));
                1: ai = 7'($urandom);
                default: ai = itm_pkg::BCAST_TEI;
            endcase
            queue_item(frame_item(itm_pkg::MT_REQUEST, 16'($urandom), ai));
            count = 1;
        end
        else if (pick < 65)
        begin
            // A check: verify, then two windows of responses and ticks.
            ai = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 126))
                                             : 7'($urandom_range(64, 126));
            queue_item(frame_item(itm_pkg::MT_VERIFY, 16'($urandom), ai));
            count = 1;
            for (int w = 0; w < 2; w++)
            begin
                r = $urandom_range(0, 9);
                n = (r < 4) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : $urandom_range(3, 5);
                for (int k = 0; k < n; k++)
                    queue_item(frame_item(itm_pkg::MT_CHECK_RESP, 16'($urandom),
                                          7'($urandom)));
                nt = (win > 16) ? $urandom_range(1, 16) : win;
                if ($urandom_range(0, 9) == 0)
                    nt = $urandom_range(0, nt);
                for (int k = 0; k < nt; k++)
                    queue_item(tick_item());
                count += n + nt;
                if ($urandom_range(0, 9) == 0)
                    queue_item(noise_item());
                else if ($urandom_range(0, 9) == 0)
                begin
                    queue_item(frame_item(itm_pkg::MT_REQUEST, 16'($urandom),
                                          itm_pkg::BCAST_TEI));
                    count++;
                end
            end
        end
        else if (pick < 80)
        begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++)
                queue_item(tick_item());
            count = n;
        end
        else if (pick < 90)
        begin
            queue_item(frame_item(itm_pkg::MT_CHECK_RESP, 16'($urandom), 7'($urandom)));
            count = 1;
        end
        else
            queue_item(noise_item());
        return count;
    endfunction

    task automatic wait_idle();
        while (accepted_count != queued_count || predicted_msgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_t201(logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        t201_copy = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_count++;
    endtask

    // Sender: bursts of items with random gaps in between.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_mgmt_item(item);
                accepted_count++;
            end
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    start <= 1'b1;
                    item  <= pending_items.pop_front();
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_pick   = $urandom_range(0, 9);
                        gap_left   = (gap_pick < 6) ? $urandom_range(0, 3) :
                                     (gap_pick < 9) ? $urandom_range(4, 15) :
                                                      $urandom_range(16, 40);
                    end
                    else
                        burst_left--;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Receiver: every strobed result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (predicted_msgs.size() == 0)
            begin
                $error("unexpected result: send_type %0d send_ref %h send_tei %0d",
                       result.send_type, result.send_ref, result.send_tei);
                error_count++;
            end
            else
            begin
                want = predicted_msgs.pop_front();
                if (result.send_type !== want.send_type)
                begin
                    $error("send_type mismatch: expected %0d, actual %0d",
                           want.send_type, result.send_type);
                    error_count++;
                end
                if (result.send_ref !== want.send_ref)
                begin
                    $error("send_ref mismatch: expected %h, actual %h",
                           want.send_ref, result.send_ref);
                    error_count++;
                end
                if (result.send_tei !== want.send_tei)
                begin
                    $error("send_tei mismatch: expected %0d, actual %0d",
                           want.send_tei, result.send_tei);
                    error_count++;
                end
                checked_count++;
                case (want.send_type)
                    itm_pkg::MT_ASSIGNED:  assigned_seen++;
                    itm_pkg::MT_DENIED:    denied_seen++;
                    itm_pkg::MT_CHECK_REQ: check_seen++;
                    default:               remove_seen++;
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("isdn_tei_manager_network_side_unit verification failed");
        $finish;
    end

    initial
    begin
        int             counted;
        int             budget;
        logic [15:0]    value;
        itm_pkg::item_t it;

        t201_copy    = itm_pkg::T201_RESET;
        alloc_ptr    = itm_pkg::DYN_BASE;
        check_on     = 1'b0;
        check_second = 1'b0;
        resp_first   = 2'd0;
        resp_second  = 2'd0;
        probe_tei    = 7'd0;
        ticks_left   = 16'd0;
        foreach (tei_taken[i])
            tei_taken[i] = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // A short stretch at the reset window length.
        counted = 0;
        while (counted < 40)
            counted += add_scenario();
        wait_idle();

        // Directed items. A zero window length behaves as one tick.
        write_t201(16'd0);
        queue_item('1);
        queue_item(frame_item(itm_pkg::MT_CHECK_RESP, 16'd0, 7'd0));
        queue_item(frame_item(itm_pkg::MT_REQUEST, 16'h0000, itm_pkg::BCAST_TEI));
        queue_item(frame_item(itm_pkg::MT_REQUEST, 16'hffff, itm_pkg::BCAST_TEI));
        queue_item(frame_item(itm_pkg::MT_REQUEST, 16'h1234, itm_pkg::DYN_BASE));
        queue_item(frame_item(itm_pkg::MT_REQUEST, 16'h5678, 7'd126));
        queue_item(frame_item(itm_pkg::MT_REQUEST, 16'h9abc, 7'd63));
        it = frame_item(itm_pkg::MT_REQUEST, 16'h0f0f, itm_pkg::BCAST_TEI);
        it.frame_ok = 1'b0;
        queue_item(it);
        it = frame_item(itm_pkg::MT_REQUEST, 16'hf0f0, itm_pkg::BCAST_TEI);
        it.entity_id = 8'hf0;
        queue_item(it);
        queue_item(frame_item(8'hff, 16'hffff, 7'h7f));
        queue_item(frame_item(8'h00, 16'h0000, 7'h00));
        queue_item(frame_item(itm_pkg::MT_VERIFY, 16'h2222, itm_pkg::BCAST_TEI));
        // Quiet check: both windows pass with no response, so the TEI is freed.
        queue_item(frame_item(itm_pkg::MT_VERIFY, 16'h3333, 7'd65));
        queue_item(itm_pkg::item_t'({itm_pkg::OP_TICK, 40'd0}));
        queue_item(tick_item());
        // Two responses in the first window remove the TEI at once.
        queue_item(frame_item(itm_pkg::MT_VERIFY, 16'h4444, 7'd66));
        queue_item(frame_item(itm_pkg::MT_CHECK_RESP, 16'h0001, 7'd66));
        queue_item(frame_item(itm_pkg::MT_CHECK_RESP, 16'h0002, 7'd66));
        queue_item(tick_item());
        // A verify during a check restarts it, here for a TEI outside the table.
        queue_item(frame_item(itm_pkg::MT_VERIFY, 16'h5555, 7'd100));
        queue_item(frame_item(itm_pkg::MT_VERIFY, 16'h6666, 7'd0));
        queue_item(tick_item());
        queue_item(tick_item());
        wait_idle();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: value = 16'd1;
                1: value = 16'd3;
                2: value = 16'hffff;
                3: value = 16'd2;
                4: value = 16'($urandom_range(1, 6));
                5: value = 16'd1;
                6: value = 16'd4;
                7: value = 16'($urandom_range(1, 8));
                default: value = 16'd2;
            endcase
            write_t201(value);
            budget  = (value > 16'd64) ? 60 : 220;
            counted = 0;
            while (counted < budget)
                counted += add_scenario();
            wait_idle();
        end

        if (predicted_msgs.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_msgs.size());
            error_count++;
        end
        $display("Checked %0d results from %0d items across %0d window settings.",
                 checked_count, accepted_count, settings_count);
        $display("Seen: %0d assigned, %0d denied, %0d check requests, %0d removes.",
                 assigned_seen, denied_seen, check_seen, remove_seen);
        if (error_count == 0)
            $display("isdn_tei_manager_network_side_unit verification clean");
        else
            $display("isdn_tei_manager_network_side_unit verification failed");
        $finish;
    end

endmodule
